[hdl/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffba_word_scan and first_fit_block_allocator.
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int WORD_W  = 32;   // bitmap bits per memory word
   localparam int POS_W   = 5;    // bit position within a word
   localparam int REQ_W   = 17;   // request size in megabytes
   localparam int IDX_W   = 11;   // reported block index
   localparam int COUNT_W = 12;   // reported block count

   localparam int DEF_NUM_BLOCKS   = 2048;
   localparam int DEF_BLOCK_MBYTES = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK,
      ST_FINISH
   } ffba_state_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } ffba_scan_result_type;

endpackage

[hdl/ffba_word_scan.sv]
// One-word step of the first-fit search over the used-block bitmap.
// Depends on ffba_pkg for the word width and the result struct.
`timescale 1ns / 1ps

module ffba_word_scan
   import ffba_pkg::*;
#(
   parameter int CNT_W = 12
) (
   input  logic [WORD_W-1:0]    used_word,
   input  logic [CNT_W-1:0]     carry,
   input  logic [CNT_W-1:0]     need,
   output ffba_scan_result_type result,
   output logic [CNT_W-1:0]     carry_out
);

   logic [WORD_W:0]   need_gt;      // need_gt[d] = need > d
   logic [WORD_W-1:0] window_ok;
   logic [WORD_W-1:0] hit_vec;
   logic [CNT_W:0]    reach [WORD_W];
   logic [POS_W-1:0]  hi_used;
   logic              any_used;

   always_comb begin
      for (int d = 0; d <= WORD_W; d++) begin
         need_gt[d] = ({1'b0, need} > (CNT_W + 1)'(d));
      end
   end

   // A run of at least need free blocks ends at bit i when every bit inside
   // the window below i is free and the run entering the word makes up the rest.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         window_ok[i] = 1'b1;
         for (int j = 0; j <= i; j++) begin
            if (used_word[j] && need_gt[i - j]) begin
               window_ok[i] = 1'b0;
            end
         end
         reach[i]   = {1'b0, carry} + (CNT_W + 1)'(i + 1);
         hit_vec[i] = window_ok[i] && (reach[i] >= {1'b0, need});
      end
   end

   always_comb begin
      result.hit = |hit_vec;
      result.pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            result.pos = POS_W'(i);
         end
      end
   end

   // Free run leaving the word at its top bit.
   always_comb begin
      hi_used  = '0;
      any_used = |used_word;
      for (int i = 0; i < WORD_W; i++) begin
         if (used_word[i]) begin
            hi_used = POS_W'(i);
         end
      end
      if (any_used) begin
         carry_out = CNT_W'(POS_W'(WORD_W - 1) - hi_used);
      end else begin
         carry_out = CNT_W'({1'b0, carry} + (CNT_W + 1)'(WORD_W));
      end
   end

endmodule

[hdl/first_fit_block_allocator.sv]
// First-fit contiguous block allocator over a used-block bitmap in one memory.
// A grant passes through the divide and check states, scans W bitmap words
// (32 blocks a word, at most NUM_WORDS), then reads and marks the M words the run spans;
// a miss skips the marking, a zero-size or oversized request skips the scan, and rsp_stall can hold the finish state.
// Throughput: one request at a time; the next beat is taken the cycle after the result loads.
// Reset clears every per-word valid bit, so the whole map reads free at once;
// a start_batch request does the same in the cycle it is accepted.
`timescale 1ns / 1ps

module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
   parameter int BLOCK_MBYTES = DEF_BLOCK_MBYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_batch,
   input  logic [REQ_W-1:0]   req_request_mbytes,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_granted,
   output logic [IDX_W-1:0]   rsp_first_block,
   output logic [IDX_W-1:0]   rsp_last_block,
   output logic [COUNT_W-1:0] rsp_block_count
);

   localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int KW        = WORD_AW + POS_W;
   localparam int CW        = $clog2(NUM_BLOCKS + 1);

   // Division by the block size as a reciprocal multiply, exact for REQ_W-bit inputs.
   localparam int DIV_SHIFT = REQ_W + $clog2(BLOCK_MBYTES);
   localparam int RECIP_W   = REQ_W + 2;
   localparam int PROD_W    = DIV_SHIFT + REQ_W;
   localparam longint unsigned DIV_RECIP_L =
      ((64'd1 << DIV_SHIFT) + 64'(BLOCK_MBYTES) - 64'd1) / 64'(BLOCK_MBYTES);
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);

   ffba_state_type state_ff, state_in;

   logic [WORD_W-1:0]    map_mem [NUM_WORDS];
   logic [WORD_W-1:0]    rd_data_ff;
   logic [NUM_WORDS-1:0] valid_ff;

   logic [REQ_W-1:0]   mbytes_ff;
   logic [REQ_W-1:0]   need_ff;
   logic [CW-1:0]      carry_ff;
   logic [WORD_AW-1:0] word_ff;
   logic [KW-1:0]      first_ff;
   logic [KW-1:0]      last_ff;
   logic               grant_ff;

   logic               rsp_valid_ff;
   logic               rsp_granted_ff;
   logic [IDX_W-1:0]   rsp_first_ff;
   logic [IDX_W-1:0]   rsp_last_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic                 req_take;
   logic                 mem_rd_en;
   logic [WORD_AW-1:0]   mem_rd_addr;
   logic                 mem_wr_en;
   logic [WORD_W-1:0]    cur_word;
   logic [WORD_W-1:0]    scan_word;
   logic [WORD_W-1:0]    mark_mask;
   logic [PROD_W-1:0]    product;
   logic                 scan_last;
   logic                 mark_last;
   logic                 need_zero;
   logic                 need_over;
   logic                 rsp_load;
   logic [KW-1:0]        hit_block;
   ffba_scan_result_type scan_res;
   logic [CW-1:0]        carry_next;

   assign req_take  = req_valid && !req_stall;
   assign product   = PROD_W'(mbytes_ff) * PROD_W'(DIV_RECIP);
   assign need_zero = (need_ff == '0);
   assign need_over = ({1'b0, need_ff} > (REQ_W + 1)'(NUM_BLOCKS));
   assign scan_last = (word_ff == WORD_AW'(NUM_WORDS - 1));
   assign mark_last = (word_ff == last_ff[KW-1:POS_W]);
   assign hit_block = {word_ff, scan_res.pos};

   // A word never written since the last clear reads as all free.
   assign cur_word = valid_ff[word_ff] ? rd_data_ff : '0;

   // Bits past the end of the map count as used; bits of the run get marked.
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         scan_word[b] = cur_word[b] ||
            ({1'b0, word_ff, POS_W'(b)} >= (KW + 1)'(NUM_BLOCKS));
         mark_mask[b] = ({word_ff, POS_W'(b)} >= first_ff) &&
                        ({word_ff, POS_W'(b)} <= last_ff);
      end
   end

   ffba_word_scan #(
      .CNT_W(CW)
   ) u_scan (
      .used_word(scan_word),
      .carry    (carry_ff),
      .need     (CW'(need_ff)),
      .result   (scan_res),
      .carry_out(carry_next)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (need_zero || need_over) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_res.hit) begin
               state_in = ST_MARK_RD;
            end else if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (mark_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_stall   = 1'b1;
      mem_rd_en   = 1'b0;
      mem_rd_addr = word_ff;
      mem_wr_en   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CHECK: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
         end
         ST_SCAN: begin
            mem_rd_en   = !scan_last;
            mem_rd_addr = WORD_AW'(word_ff + 1'b1);
         end
         ST_MARK_RD: begin
            mem_rd_en = 1'b1;
         end
         ST_MARK: begin
            mem_wr_en   = 1'b1;
            mem_rd_en   = !mark_last;
            mem_rd_addr = WORD_AW'(word_ff + 1'b1);
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Bitmap memory: read next word while writing back the current one
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         map_mem[word_ff] <= cur_word | mark_mask;
      end
      if (mem_rd_en) begin
         rd_data_ff <= map_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_take && req_start_batch) begin
            valid_ff <= '0;
         end else if (mem_wr_en) begin
            valid_ff[word_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mbytes_ff <= req_request_mbytes;
            end
         end
         ST_DIVIDE: begin
            need_ff <= product[DIV_SHIFT +: REQ_W];
         end
         ST_CHECK: begin
            word_ff  <= '0;
            carry_ff <= '0;
            grant_ff <= need_zero;
            first_ff <= '0;
            last_ff  <= '0;
         end
         ST_SCAN: begin
            if (scan_res.hit) begin
               grant_ff <= 1'b1;
               last_ff  <= hit_block;
               first_ff <= KW'(hit_block + 1'b1 - KW'(need_ff));
               word_ff  <= WORD_AW'(KW'(hit_block + 1'b1 - KW'(need_ff)) >> POS_W);
            end else if (!scan_last) begin
               word_ff  <= WORD_AW'(word_ff + 1'b1);
               carry_ff <= carry_next;
            end
         end
         ST_MARK: begin
            if (!mark_last) begin
               word_ff <= WORD_AW'(word_ff + 1'b1);
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_granted_ff <= grant_ff;
               rsp_first_ff   <= IDX_W'(first_ff);
               rsp_last_ff    <= IDX_W'(last_ff);
               rsp_count_ff   <= COUNT_W'(need_ff);
            end
         end
         default: begin
            // hold
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_first_block = rsp_first_ff;
   assign rsp_last_block  = rsp_last_ff;
   assign rsp_block_count = rsp_count_ff;

endmodule
